### rtl/det_pkg.sv
// shared types, codes and helpers of the directory entry table
package det_pkg;

  localparam int NAME_W  = 64;
  localparam int INODE_W = 16;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 3;

  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_PUT    = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
  localparam logic [OP_W-1:0] OP_LIST   = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK         = 3'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND  = 3'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_DIR    = 3'd2;
  localparam logic [STAT_W-1:0] STAT_NO_SPACE   = 3'd3;
  localparam logic [STAT_W-1:0] STAT_LIST_EMPTY = 3'd4;

  localparam logic [NAME_W-1:0] NAME_DOT    = 64'h2E;
  localparam logic [NAME_W-1:0] NAME_DOTDOT = 64'h2E2E;

  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [NAME_W-1:0]  entry_name;
    logic [INODE_W-1:0] inode_number;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [INODE_W-1:0] found_inode;
    logic [NAME_W-1:0]  listed_name;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [NAME_W-1:0]  name;
    logic [INODE_W-1:0] inode;
  } slot_t;

  typedef struct packed {
    logic en;
    logic bwd;
  } shift_ctl_t;

  // cut a name at its first zero byte and at nbytes bytes
  function automatic logic [NAME_W-1:0] clean_name(input logic [NAME_W-1:0] raw,
                                                    input int nbytes);
    logic [NAME_W-1:0] r;
    logic keep;
    r = '0;
    keep = 1'b1;
    for (int i = 0; i < NAME_W / 8; i++) begin
      if (raw[8*i +: 8] == 8'h00 || i >= nbytes) keep = 1'b0;
      if (keep) r[8*i +: 8] = raw[8*i +: 8];
    end
    return r;
  endfunction

endpackage

### rtl/det_cell.sv
// one slot of the table ring, shifting toward either neighbor
module det_cell import det_pkg::*; (
  input  logic       clk,
  input  shift_ctl_t ctl,
  input  slot_t      from_up,
  input  slot_t      from_dn,
  output slot_t      slot_q
);

  slot_t slot_r;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      slot_r <= ctl.bwd ? from_dn : from_up;
    end
  end

  assign slot_q = slot_r;

endmodule

### rtl/det_ctrl.sv
// head controller: operation sequencing, ring feed, result register
module det_ctrl import det_pkg::*; #(
  parameter int MAX_ENTRIES = 64,
  parameter int NAME_BYTES  = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  slot_t      head,
  input  slot_t      head_next,
  input  slot_t      tail,
  output slot_t      feed,
  output shift_ctl_t ring_ctl
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] N_CW   = CW'(MAX_ENTRIES);
  localparam logic [CW-1:0] LAST_T = CW'(MAX_ENTRIES - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_FINAL = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [CW-1:0]      t_r, t_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               found_r, found_nxt;
  logic               app_r, app_nxt;
  logic               pend_v_r, pend_v_nxt;
  logic               notdir_r, notdir_nxt;
  logic               is_dir_r, is_dir_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [OP_W-1:0]    op_r, op_nxt;
  logic [NAME_W-1:0]  name_r, name_nxt;
  logic [INODE_W-1:0] ino_r, ino_nxt;
  logic [INODE_W-1:0] res_ino_r, res_ino_nxt;
  slot_t              pend_r, pend_nxt;
  out_item_t          out_r, out_nxt;

  logic          in_acc, out_free, scanning, step, hit, skip, cand, is_dot;
  logic          in_rng_f, in_rng_b, append_ok;
  logic [CW-1:0] idx_b;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign scanning  = (state_r == S_SCAN);

  assign in_rng_f  = (t_r < cnt_r);
  assign append_ok = (t_r == cnt_r) && (cnt_r != N_CW);
  assign idx_b     = LAST_T - t_r;
  assign in_rng_b  = (idx_b < cnt_r);
  assign is_dot    = (tail.name == NAME_DOT) || (tail.name == NAME_DOTDOT);
  assign cand      = in_rng_b && !is_dot;

  always_comb begin
    hit = 1'b0;
    unique case (op_r)
      OP_LOOKUP: hit = !found_r && in_rng_f && (head.name == name_r);
      OP_PUT:    hit = !found_r && ((in_rng_f && (head.name[7:0] == 8'h00)) || append_ok);
      OP_DELETE: hit = !found_r && in_rng_f && (head.name != '0) && (head.name == name_r);
      OP_LIST:   hit = 1'b0;
      default:   hit = 1'b0;
    endcase
  end

  assign skip = (op_r == OP_DELETE) && (found_r || hit);
  assign step = scanning && !((op_r == OP_LIST) && cand && pend_v_r && !out_free);

  assign ring_ctl.en  = step;
  assign ring_ctl.bwd = (op_r == OP_LIST);

  always_comb begin
    feed = head;
    if (op_r == OP_PUT && hit) begin
      feed.name  = name_r;
      feed.inode = ino_r;
    end else if (skip) begin
      feed = (t_r == LAST_T) ? '0 : head_next;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    t_nxt         = t_r;
    cnt_nxt       = cnt_r;
    found_nxt     = found_r;
    app_nxt       = app_r;
    pend_v_nxt    = pend_v_r;
    notdir_nxt    = notdir_r;
    is_dir_nxt    = is_dir_r;
    op_nxt        = op_r;
    name_nxt      = name_r;
    ino_nxt       = ino_r;
    res_ino_nxt   = res_ino_r;
    pend_nxt      = pend_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (cfg_wr_en) is_dir_nxt = cfg_wr_data;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt     = in_data.opcode;
          name_nxt   = clean_name(in_data.entry_name, NAME_BYTES);
          ino_nxt    = in_data.inode_number;
          t_nxt      = '0;
          found_nxt  = 1'b0;
          app_nxt    = 1'b0;
          pend_v_nxt = 1'b0;
          notdir_nxt = (in_data.opcode != OP_LOOKUP) && !is_dir_r;
          state_nxt  = notdir_nxt ? S_FINAL : S_SCAN;
        end
      end
      S_SCAN: begin
        if (step) begin
          t_nxt     = t_r + CW'(1);
          found_nxt = found_r || hit;
          if (op_r == OP_LOOKUP && hit) res_ino_nxt = head.inode;
          if (op_r == OP_PUT && hit && !in_rng_f) app_nxt = 1'b1;
          if (op_r == OP_LIST && cand) begin
            pend_nxt   = tail;
            pend_v_nxt = 1'b1;
            if (pend_v_r) begin
              // a further entry follows, so the pending one is not the last
              out_nxt.status      = STAT_OK;
              out_nxt.found_inode = pend_r.inode;
              out_nxt.listed_name = pend_r.name;
              out_nxt.last        = 1'b0;
              out_valid_nxt       = 1'b1;
            end
          end
          if (t_r == LAST_T) state_nxt = S_FINAL;
        end
      end
      S_FINAL: begin
        if (out_free) begin
          out_nxt.status      = STAT_OK;
          out_nxt.found_inode = '0;
          out_nxt.listed_name = '0;
          out_nxt.last        = 1'b1;
          if (notdir_r) begin
            out_nxt.status = STAT_NOT_DIR;
          end else begin
            unique case (op_r)
              OP_LOOKUP: begin
                out_nxt.status      = found_r ? STAT_OK : STAT_NOT_FOUND;
                out_nxt.found_inode = found_r ? res_ino_r : '0;
              end
              OP_PUT: begin
                out_nxt.status = found_r ? STAT_OK : STAT_NO_SPACE;
                if (app_r) cnt_nxt = cnt_r + CW'(1);
              end
              OP_DELETE: begin
                out_nxt.status = found_r ? STAT_OK : STAT_NOT_FOUND;
                if (found_r) cnt_nxt = cnt_r - CW'(1);
              end
              OP_LIST: begin
                if (pend_v_r) begin
                  out_nxt.found_inode = pend_r.inode;
                  out_nxt.listed_name = pend_r.name;
                end else begin
                  out_nxt.status = STAT_LIST_EMPTY;
                end
              end
              default: out_nxt.status = STAT_NOT_FOUND;
            endcase
          end
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      t_r         <= '0;
      cnt_r       <= '0;
      found_r     <= 1'b0;
      app_r       <= 1'b0;
      pend_v_r    <= 1'b0;
      notdir_r    <= 1'b0;
      is_dir_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      t_r         <= t_nxt;
      cnt_r       <= cnt_nxt;
      found_r     <= found_nxt;
      app_r       <= app_nxt;
      pend_v_r    <= pend_v_nxt;
      notdir_r    <= notdir_nxt;
      is_dir_r    <= is_dir_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    name_r    <= name_nxt;
    ino_r     <= ino_nxt;
    res_ino_r <= res_ino_nxt;
    pend_r    <= pend_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### rtl/directory_entry_table.sv
// top level of the directory entry table: slot ring and head controller
// The table is a ring of MAX_ENTRIES slot cells that shifts by one slot per
// cycle unless held, past a controller at its head, so every lookup, and
// every put, delete and list on a directory, walks the whole ring once and
// the ring ends where it started. An operation is taken, walks the ring and
// loads its final result beat once the result register is free; put,
// delete and list on a table that is not a directory skip the walk. A list
// beat that meets a stalled result register holds the ring for as long as
// the stall lasts. Delete closes the gap while the ring passes. One item is
// in work at a time; the input stalls until its last result is loaded.
module directory_entry_table import det_pkg::*; #(
  parameter int MAX_ENTRIES = 64,
  parameter int NAME_BYTES  = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data
);

  slot_t      slots [MAX_ENTRIES];
  slot_t      feed;
  shift_ctl_t ring_ctl;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    slot_t up_d, dn_d;
    if (i == MAX_ENTRIES - 1) begin : g_top
      assign up_d = feed;
    end else begin : g_mid
      assign up_d = slots[i+1];
    end
    if (i == 0) begin : g_bot
      assign dn_d = slots[MAX_ENTRIES-1];
    end else begin : g_low
      assign dn_d = slots[i-1];
    end
    det_cell u_cell (
      .clk     (clk),
      .ctl     (ring_ctl),
      .from_up (up_d),
      .from_dn (dn_d),
      .slot_q  (slots[i])
    );
  end

  det_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .NAME_BYTES  (NAME_BYTES)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .head        (slots[0]),
    .head_next   (slots[1]),
    .tail        (slots[MAX_ENTRIES-1]),
    .feed        (feed),
    .ring_ctl    (ring_ctl)
  );

endmodule

### rtl/det_chk.sv
// port checker for the directory entry table and its bind
module det_chk import det_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed under stall");

  // one item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while busy");

  // only list entries are followed by more beats
  a_not_last_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> out_data.status == STAT_OK)
    else $error("non-final beat with failure status");

  // failures carry no inode and no name
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != STAT_OK |->
      out_data.found_inode == '0 && out_data.listed_name == '0)
    else $error("failure beat with payload");

  // reset empties the result register
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind directory_entry_table det_chk u_det_chk (.*);

### test/directory_entry_table_tb.sv
// self-checking testbench for the directory entry table: random and directed beats
module directory_entry_table_tb;
  import det_pkg::*;

  localparam int SLOTS       = 64;
  localparam int POOL        = 20;
  localparam int HOLD_CYCLES = 400;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      cfg_wr_en;
  logic      cfg_wr_data;

  bit sender_idles;
  bit receiver_stalls;
  bit hold_go;
  int hold_left;

  class dir_table_scoreboard;
    logic [NAME_W-1:0]  slot_name  [SLOTS];
    logic [INODE_W-1:0] slot_inode [SLOTS];
    int        used;
    bit        is_dir;
    out_item_t expected_q[$];
    int        mismatches;
    int        beats_in;
    int        beats_out;
    int        list_entries;
    int        peak_used;
    int        refused;

    function new();
      used = 0;
      is_dir = 1'b1;
      mismatches = 0;
      beats_in = 0;
      beats_out = 0;
      list_entries = 0;
      peak_used = 0;
      refused = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // drop bytes from the first zero byte on
    function logic [NAME_W-1:0] trim(logic [NAME_W-1:0] raw);
      logic [NAME_W-1:0] r;
      bit cut;
      r = '0;
      cut = 1'b0;
      for (int b = 0; b < NAME_W / 8; b++) begin
        if (raw[8*b +: 8] == 8'h00) cut = 1'b1;
        if (!cut) r[8*b +: 8] = raw[8*b +: 8];
      end
      return r;
    endfunction

    function void note_input(in_item_t it);
      logic [NAME_W-1:0] nm;
      out_item_t r;
      int hit;
      bit have;
      nm = trim(it.entry_name);
      r = '0;
      r.status = STAT_OK;
      r.last = 1'b1;
      hit = -1;
      beats_in++;
      if (it.opcode == OP_LOOKUP) begin
        for (int i = 0; i < used; i++)
          if (hit < 0 && slot_name[i] == nm) hit = i;
        if (hit >= 0) r.found_inode = slot_inode[hit];
        else r.status = STAT_NOT_FOUND;
        expected_q.push_back(r);
      end else if (!is_dir) begin
        r.status = STAT_NOT_DIR;
        expected_q.push_back(r);
      end else if (it.opcode == OP_PUT) begin
        for (int i = 0; i < used; i++)
          if (hit < 0 && slot_name[i][7:0] == 8'h00) hit = i;
        if (hit < 0 && used >= SLOTS) begin
          r.status = STAT_NO_SPACE;
          refused++;
        end else begin
          if (hit < 0) begin
            hit = used;
            used++;
          end
          slot_name[hit] = nm;
          slot_inode[hit] = it.inode_number;
        end
        if (used > peak_used) peak_used = used;
        expected_q.push_back(r);
      end else if (it.opcode == OP_DELETE) begin
        for (int i = 0; i < used; i++)
          if (hit < 0 && slot_name[i] != '0 && slot_name[i] == nm) hit = i;
        if (hit < 0) begin
          r.status = STAT_NOT_FOUND;
        end else begin
          for (int j = hit; j < used - 1; j++) begin
            slot_name[j] = slot_name[j+1];
            slot_inode[j] = slot_inode[j+1];
          end
          slot_name[used-1] = '0;
          slot_inode[used-1] = '0;
          used--;
        end
        expected_q.push_back(r);
      end else begin
        have = 1'b0;
        for (int i = used - 1; i >= 0; i--) begin
          if (slot_name[i] != NAME_DOT && slot_name[i] != NAME_DOTDOT) begin
            if (have) expected_q.push_back(r);
            r = '0;
            r.status = STAT_OK;
            r.found_inode = slot_inode[i];
            r.listed_name = slot_name[i];
            have = 1'b1;
            list_entries++;
          end
        end
        if (!have) begin
          r = '0;
          r.status = STAT_LIST_EMPTY;
        end
        r.last = 1'b1;
        expected_q.push_back(r);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      beats_out++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: status %0d inode %h name %h last %0b",
                   got.status, got.found_inode, got.listed_name, got.last);
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status || got.found_inode !== want.found_inode ||
          got.listed_name !== want.listed_name || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result mismatch: expected status %0d inode %h name %h last %0b",
                   want.status, want.found_inode, want.listed_name, want.last);
          $display("                 actual   status %0d inode %h name %h last %0b",
                   got.status, got.found_inode, got.listed_name, got.last);
        end
      end
    endfunction
  endclass

  dir_table_scoreboard sb;

  directory_entry_table #(
    .MAX_ENTRIES(SLOTS),
    .NAME_BYTES (8)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("directory_entry_table regression: fail");
    $finish;
  end

  // beat monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      if (in_valid && !in_stall) sb.note_input(in_data);
    end
  end

  // result side backpressure
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= receiver_stalls && ($urandom_range(99) < 12);
      end
    end
  end

  function automatic logic [NAME_W-1:0] pack_name(string s);
    logic [NAME_W-1:0] n;
    n = '0;
    for (int b = 0; b < s.len() && b < 8; b++) n[8*b +: 8] = s[b];
    return n;
  endfunction

  function automatic logic [NAME_W-1:0] pool_name(int k);
    logic [NAME_W-1:0] n;
    int len;
    n = '0;
    len = 1 + k % 8;
    for (int j = 0; j < len; j++) n[8*j +: 8] = 8'h61 + 8'((k * 5 + j * 3) % 26);
    return n;
  endfunction

  function automatic logic [NAME_W-1:0] pick_name();
    logic [NAME_W-1:0] n;
    int sel;
    int k;
    int len;
    sel = $urandom_range(99);
    if (sel < 4) return NAME_DOT;
    if (sel < 8) return NAME_DOTDOT;
    if (sel < 12) return '0;
    if (sel < 30) return {$urandom, $urandom};
    k = $urandom_range(POOL - 1);
    n = pool_name(k);
    len = 1 + k % 8;
    // junk past the terminating zero
    if (len < 7 && $urandom_range(1) == 1) n = n | ({$urandom, $urandom} << (8 * (len + 1)));
    return n;
  endfunction

  task automatic offer(logic [OP_W-1:0] op, logic [NAME_W-1:0] nm,
                       logic [INODE_W-1:0] ino);
    in_item_t it;
    it.opcode = op;
    it.entry_name = nm;
    it.inode_number = ino;
    while (sender_idles && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic set_directory(bit v);
    wait_for_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.is_dir = v;
  endtask

  task automatic run_random(int n, int w_put, int w_del, int w_list);
    int sel;
    logic [OP_W-1:0] op;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < w_put) op = OP_PUT;
      else if (sel < w_put + w_del) op = OP_DELETE;
      else if (sel < w_put + w_del + w_list) op = OP_LIST;
      else op = OP_LOOKUP;
      offer(op, pick_name(), INODE_W'($urandom_range(65535)));
    end
  endtask

  initial begin
    sb = new();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= 1'b0;
    sender_idles = 1'b1;
    receiver_stalls = 1'b1;
    hold_go = 1'b0;
    hold_left = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    set_directory(1'b1);

    // empty table, dot entries, trimming, name and inode extremes
    offer(OP_LOOKUP, pack_name("a"), 16'h0000);
    offer(OP_LIST, '0, 16'h0000);
    offer(OP_DELETE, '0, 16'h0000);
    offer(OP_PUT, pack_name("."), 16'h0001);
    offer(OP_PUT, 64'h7A79_7800_0000_2E2E, 16'h0002);
    offer(OP_LIST, '0, 16'hFFFF);
    offer(OP_LOOKUP, pack_name("."), 16'h0000);
    offer(OP_PUT, 64'h7A79_7800_0000_6261, 16'hFFFF);
    offer(OP_LOOKUP, pack_name("ab"), 16'h0000);
    offer(OP_PUT, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0000);
    offer(OP_PUT, '0, 16'h1234);
    offer(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FF00, 16'h0000);
    offer(OP_PUT, pack_name("cd"), 16'h5678);
    offer(OP_PUT, '0, 16'h9ABC);
    offer(OP_DELETE, '0, 16'h0000);
    offer(OP_DELETE, pack_name("ab"), 16'h0000);
    offer(OP_DELETE, pack_name("ab"), 16'h0000);
    offer(OP_LIST, '0, 16'h0000);
    offer(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0000);
    set_directory(1'b0);
    offer(OP_PUT, pack_name("zz"), 16'h0042);
    offer(OP_DELETE, pack_name("cd"), 16'h0000);
    offer(OP_LIST, '0, 16'h0000);
    offer(OP_LOOKUP, pack_name("cd"), 16'h0000);
    set_directory(1'b1);
    offer(OP_LIST, '0, 16'h0000);

    run_random(150, 35, 20, 15);

    // fill the table without any idling on either side
    sender_idles = 1'b0;
    receiver_stalls = 1'b0;
    run_random(80, 85, 0, 5);
    sender_idles = 1'b1;
    receiver_stalls = 1'b1;

    set_directory(1'b0);
    run_random(40, 30, 20, 20);
    set_directory(1'b1);

    // long result stall while beats keep coming
    hold_go = 1'b1;
    run_random(100, 20, 40, 25);
    run_random(80, 10, 70, 10);

    wait_for_results();
    repeat (SLOTS + 8) @(posedge clk);
    $display("covered %0d operations and %0d result beats, %0d of them list entries",
             sb.beats_in, sb.beats_out, sb.list_entries);
    $display("table peaked at %0d of %0d slots, %0d puts refused as full",
             sb.peak_used, SLOTS, sb.refused);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("directory_entry_table regression: pass");
    else
      $display("directory_entry_table regression: fail");
    $finish;
  end

endmodule

### filelist.f
rtl/det_pkg.sv
rtl/det_cell.sv
rtl/det_ctrl.sv
rtl/directory_entry_table.sv
rtl/det_chk.sv
test/directory_entry_table_tb.sv
